### rtl/core/bucketed_priority_message_queue_top_macros.svh
// ----------------------------------------------------------------------------
// bucketed priority message queue assertion macros
// concurrent checks clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef BUCKETED_PRIORITY_MESSAGE_QUEUE_TOP_MACROS_SVH
`define BUCKETED_PRIORITY_MESSAGE_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BPMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define BPMQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define BPMQ_ASSERT(lbl, prop, msg)

`define BPMQ_NEVER(lbl, expr, msg)

`endif

`endif

### rtl/core/bpmq_pkg.sv
// ----------------------------------------------------------------------------
// bpmq_pkg
// shared constants, types and key encoding for the bucketed priority queue
// ----------------------------------------------------------------------------
package bpmq_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;
  localparam int STORE_W     = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KEY_W       = 34;

  localparam logic [31:0] PRIO_BIAS = 32'h8000_0000;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] STRAT_FIFO  = 2'd0;
  localparam logic [1:0] STRAT_LIFO  = 2'd1;
  localparam logic [1:0] STRAT_IFIFO = 2'd2;
  localparam logic [1:0] STRAT_ILIFO = 2'd3;

  localparam logic [1:0] CLS_NEG   = 2'd0;
  localparam logic [1:0] CLS_ZERO  = 2'd1;
  localparam logic [1:0] CLS_POS   = 2'd2;
  localparam logic [1:0] CLS_EMPTY = 2'd3;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STORE_W-1:0] handle_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    logic   front;
    entry_t ent;
  } cell_cmd_t;

  function automatic key_t make_key(logic [1:0] strategy, logic [31:0] prio);
    logic [31:0] biased;
    key_t        key;
    biased = prio ^ PRIO_BIAS;
    case (strategy) inside
      STRAT_FIFO, STRAT_LIFO: key = {CLS_ZERO, 32'd0};
      default:                key = {(biased[31] ? CLS_POS : CLS_NEG), biased};
    endcase
    return key;
  endfunction

  function automatic logic is_front(logic [1:0] strategy);
    logic f;
    case (strategy) inside
      STRAT_LIFO, STRAT_ILIFO: f = 1'b1;
      default:                 f = 1'b0;
    endcase
    return f;
  endfunction

endpackage

### rtl/core/bpmq_cell.sv
// ----------------------------------------------------------------------------
// bpmq_cell
// one slot of the sorted chain: holds an entry, compares against the new key,
// shifts toward the tail on insert and toward the head on removal
// ----------------------------------------------------------------------------
module bpmq_cell
  import bpmq_pkg::*;
(
  input  logic      clk,
  input  logic      occ,
  input  cell_cmd_t cmd,
  input  logic      left_ins,
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  output logic      ins,
  output entry_t    ent
);

  logic ge;
  logic gt;

  assign ge  = ent.key >= cmd.ent.key;
  assign gt  = ent.key > cmd.ent.key;
  assign ins = !occ || (cmd.front ? ge : gt);

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (left_ins) begin
        ent <= left_ent;
      end else if (ins) begin
        ent <= cmd.ent;
      end
    end else if (cmd.deq) begin
      ent <= right_ent;
    end
  end

endmodule

### rtl/core/bucketed_priority_message_queue_top.sv
// ----------------------------------------------------------------------------
// bucketed_priority_message_queue_top
// priority queue of message handles with fifo/lifo buckets, built as a
// sorted chain of slot cells
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries op, strategy, priority_req and
//   payload. op enqueue places the handle by class and priority, op dequeue
//   pops the slot at the head of the chain.
//   output channel (out_valid/out_stall) carries one result item per input
//   item: got_item, out_payload, dropped, head_class, head_priority,
//   queue_length and max_length.
//   the result is registered and presented in the cycle after the item is accepted.
//   throughput: one item per cycle while out_stall does not hold a result;
//   every slot cell decides its move in the same cycle from its own compare
//   and its neighbors, so insert and removal cost the same at any queue length.
//   a waiting result sits in the output register; a new item is accepted in
//   the cycle that result is taken. while out_stall holds a result, in_stall
//   is high and queue state does not move.
//   reset (rst, synchronous) empties the queue, clears the high-water mark
//   and out_valid; in_stall is high during reset.
// ----------------------------------------------------------------------------
`include "bucketed_priority_message_queue_top_macros.svh"

module bucketed_priority_message_queue_top
  import bpmq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [1:0]         strategy,
  input  logic signed [31:0] priority_req,
  input  logic [31:0]        payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               got_item,
  output logic [31:0]        out_payload,
  output logic               dropped,
  output logic [1:0]         head_class,
  output logic signed [31:0] head_priority,
  output logic [6:0]         queue_length,
  output logic [6:0]         max_length
);

  count_t    count;
  count_t    count_next;
  count_t    high_water;
  count_t    high_water_next;
  logic      in_acc;
  logic      full;
  logic      empty;
  cell_cmd_t cmd;
  entry_t    ents [CAPACITY];
  logic      ins  [CAPACITY];
  entry_t    head_next;
  key_t      head_key;
  logic [1:0] head_cls;

  assign in_stall = rst || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign full     = count == count_t'(CAPACITY);
  assign empty    = count == '0;

  always_comb begin
    cmd.enq        = in_acc && (op == OP_ENQ) && !full;
    cmd.deq        = in_acc && (op == OP_DEQ) && !empty;
    cmd.front      = is_front(strategy);
    cmd.ent.key    = make_key(strategy, priority_req);
    cmd.ent.handle = payload[STORE_W-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   l_ins;
    entry_t l_ent;
    entry_t r_ent;
    assign occ = count_t'(i) < count;
    if (i == 0) begin : g_head
      assign l_ins = 1'b0;
      assign l_ent = cmd.ent;
    end else begin : g_mid
      assign l_ins = ins[i-1];
      assign l_ent = ents[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_ent = '0;
    end else begin : g_body
      assign r_ent = ents[i+1];
    end
    bpmq_cell u_cell (
      .clk       (clk),
      .occ       (occ),
      .cmd       (cmd),
      .left_ins  (l_ins),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .ins       (ins[i]),
      .ent       (ents[i])
    );
  end

  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + count_t'(1);
    end else if (cmd.deq) begin
      count_next = count - count_t'(1);
    end
    high_water_next = (count_next > high_water) ? count_next : high_water;
    if (cmd.enq) begin
      head_next = ins[0] ? cmd.ent : ents[0];
    end else if (cmd.deq) begin
      head_next = ents[1];
    end else begin
      head_next = ents[0];
    end
    head_key = head_next.key;
    head_cls = (count_next == '0) ? CLS_EMPTY : head_key[KEY_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      high_water <= '0;
      out_valid  <= 1'b0;
    end else begin
      count      <= count_next;
      high_water <= high_water_next;
      if (in_acc) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      got_item     <= cmd.deq;
      out_payload  <= cmd.deq ? 32'(ents[0].handle) : 32'd0;
      dropped      <= (op == OP_ENQ) && full;
      head_class   <= head_cls;
      head_priority <= (head_cls == CLS_EMPTY || head_cls == CLS_ZERO) ?
                       32'sd0 : $signed(head_key[31:0] ^ PRIO_BIAS);
      queue_length <= 7'(count_next);
      max_length   <= 7'(high_water_next);
    end
  end

  `BPMQ_NEVER(a_count_range, count > count_t'(CAPACITY), "queue count above capacity")
  `BPMQ_NEVER(a_high_water, high_water < count, "high-water mark below count")
  `BPMQ_ASSERT(a_full_drop, in_acc && op == OP_ENQ && full |=> out_valid && dropped && !got_item, "full enqueue not dropped")
  `BPMQ_ASSERT(a_deq_count, in_acc && op == OP_DEQ && !empty |=> got_item && count == $past(count) - count_t'(1), "dequeue did not pop")
  `BPMQ_NEVER(a_got_drop, out_valid && got_item && dropped, "item both dequeued and dropped")

endmodule
